// ===== hw/rtl/pgf_pkg.sv =====
// Shared types, field layout and codes of the partition gap fit finder.
`timescale 1ns / 1ps
package pgf_pkg;

   localparam int N_ENTRIES = 4;
   localparam int ADDR_W    = 31;
   localparam int SUM_W     = 33;
   localparam int HDR_W     = 16;
   localparam int KIND_W    = 2;
   localparam int FIT_W     = 2;
   localparam int RANK_W    = $clog2(N_ENTRIES);
   localparam int N_GAPS    = N_ENTRIES + 1;

   localparam int LEN_BASE  = N_ENTRIES * ADDR_W;
   localparam int KIND_BASE = 2 * N_ENTRIES * ADDR_W;
   localparam int REQ_BASE  = KIND_BASE + KIND_W * N_ENTRIES;
   localparam int REQ_BITS  = REQ_BASE + ADDR_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int REQ_USER_W = FIT_W + 1;
   localparam int RSP_DATA_W = ((ADDR_W + 7) / 8) * 8;

   localparam int CSR_IDX_W = 1;

   localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EXTENDED = 2'd1;

   localparam logic [FIT_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_DISK_SIZE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTES = 1'd1;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
      logic [KIND_W-1:0] kind;
      logic              used;
   } pgf_slot_type;

   typedef struct packed {
      logic [SUM_W-1:0] lo;
      logic [SUM_W-1:0] hi;
      logic             exists;
   } pgf_gap_type;

   typedef struct packed {
      logic [SUM_W-1:0] es;
      logic [SUM_W-1:0] ee;
      logic             has;
   } pgf_ext_type;

   typedef struct packed {
      logic             adequate;
      logic [SUM_W-1:0] size;
      logic [SUM_W-1:0] offset;
   } pgf_fit_type;

   typedef struct packed {
      logic clip;
      logic size;
   } pgf_lane_en_type;

endpackage

// ===== hw/rtl/pgf_sort.sv =====
// Stable sort of the used table entries by start offset.
`timescale 1ns / 1ps
module pgf_sort
   import pgf_pkg::*;
(
   input  logic                  clock,
   input  logic                  en,
   input  logic [REQ_DATA_W-1:0] tdata,
   input  logic [REQ_USER_W-1:0] tuser,
   output pgf_slot_type          slot_ff [N_ENTRIES],
   output logic [ADDR_W-1:0]     req_size_ff,
   output logic [FIT_W-1:0]      fit_ff,
   output logic                  logical_ff
);

   logic [ADDR_W-1:0] st [N_ENTRIES];
   logic [ADDR_W-1:0] ln [N_ENTRIES];
   logic [KIND_W-1:0] kd [N_ENTRIES];
   logic              us [N_ENTRIES];
   logic [RANK_W-1:0] rank [N_ENTRIES];
   pgf_slot_type      slot_in [N_ENTRIES];

   always_comb begin
      logic [RANK_W:0] cnt;
      for (int i = 0; i < N_ENTRIES; i++) begin
         st[i] = tdata[i*ADDR_W +: ADDR_W];
         ln[i] = tdata[LEN_BASE + i*ADDR_W +: ADDR_W];
         kd[i] = tdata[KIND_BASE + i*KIND_W +: KIND_W];
         us[i] = (kd[i] != KIND_UNUSED);
      end
      for (int i = 0; i < N_ENTRIES; i++) begin
         cnt = '0;
         for (int j = 0; j < N_ENTRIES; j++) begin
            if (j != i && us[j] && ((st[j] < st[i]) || (st[j] == st[i] && j < i))) begin
               cnt = cnt + 1'b1;
            end
         end
         rank[i] = cnt[RANK_W-1:0];
      end
      for (int k = 0; k < N_ENTRIES; k++) begin
         slot_in[k] = '0;
         for (int i = 0; i < N_ENTRIES; i++) begin
            if (us[i] && rank[i] == RANK_W'(k)) begin
               slot_in[k].start  = st[i];
               slot_in[k].length = ln[i];
               slot_in[k].kind   = kd[i];
               slot_in[k].used   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         slot_ff     <= slot_in;
         req_size_ff <= tdata[REQ_BASE +: ADDR_W];
         fit_ff      <= tuser[FIT_W-1:0];
         logical_ff  <= tuser[FIT_W];
      end
   end

endmodule

// ===== hw/rtl/pgf_gap_lane.sv =====
// One gap lane: clip to the extended entry in logical mode, then size and adequacy check.
`timescale 1ns / 1ps
module pgf_gap_lane
   import pgf_pkg::*;
(
   input  logic              clock,
   input  pgf_lane_en_type   en,
   input  pgf_gap_type       gap,
   input  pgf_ext_type       ext,
   input  logic              logical,
   input  logic [ADDR_W-1:0] req_size,
   output pgf_fit_type       fit_ff
);

   pgf_gap_type clip_in;
   pgf_gap_type clip_ff;
   pgf_fit_type fit_in;

   always_comb begin
      if (logical) begin
         clip_in.lo     = (gap.lo > ext.es) ? gap.lo : ext.es;
         clip_in.hi     = (gap.hi < ext.ee) ? gap.hi : ext.ee;
         clip_in.exists = gap.exists && ext.has && (clip_in.lo < clip_in.hi);
      end else begin
         clip_in = gap;
      end
   end

   always_comb begin
      fit_in.size     = clip_ff.hi - clip_ff.lo;
      fit_in.offset   = clip_ff.lo;
      fit_in.adequate = clip_ff.exists && (fit_in.size >= {2'b00, req_size});
   end

   always_ff @(posedge clock) begin
      if (en.clip) begin
         clip_ff <= clip_in;
      end
      if (en.size) begin
         fit_ff <= fit_in;
      end
   end

endmodule

// ===== hw/rtl/pgf_merge.sv =====
// Merge of the lane results by first, best or worst fit into the result register.
`timescale 1ns / 1ps
module pgf_merge
   import pgf_pkg::*;
(
   input  logic                  clock,
   input  logic                  en,
   input  pgf_fit_type           lane [N_GAPS],
   input  logic [FIT_W-1:0]      fit_mode,
   output logic                  found_ff,
   output logic [ADDR_W-1:0]     place_ff
);

   logic              found_in;
   logic [SUM_W-1:0]  pick_off;
   logic [SUM_W-1:0]  pick_size;

   always_comb begin
      logic take;
      found_in  = 1'b0;
      pick_off  = '0;
      pick_size = '0;
      for (int i = 0; i < N_GAPS; i++) begin
         case (fit_mode)
            FIT_FIRST: take = !found_in;
            FIT_BEST:  take = !found_in || (lane[i].size < pick_size);
            FIT_WORST: take = !found_in || (lane[i].size > pick_size);
            default:   take = 1'b0;
         endcase
         if (lane[i].adequate && take) begin
            found_in  = 1'b1;
            pick_off  = lane[i].offset;
            pick_size = lane[i].size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         found_ff <= found_in;
         place_ff <= found_in ? pick_off[ADDR_W-1:0] : '0;
      end
   end

endmodule

// ===== hw/rtl/partition_gap_fit_finder.sv =====
// Top level of the partition gap fit finder: pipeline control, gap listing, lanes.
//
// req_* carries one placement request per transfer: the partition table, the
// requested size, the fit mode and the logical flag. rsp_* returns one result
// per request, in order: found in rsp_tuser, the gap start in rsp_tdata.
// csr_* writes disk_size (index 0) and header_bytes (index 1); csr_ready is
// always high and writes belong to idle periods.
// Five stage registers lie between the request transfer and rsp_tvalid: sort,
// gap listing, clip, size check, fit merge. One request is taken every cycle
// while rsp_tready does not stall the pipeline, with one gap lane per table
// entry plus one for the tail gap working side by side.
// Each stage holds only while its successor is full and stalled, so empty
// stages still fill while rsp_tready is low; req_tready drops once all
// stages hold data and rsp_tready is low.
// Synchronous reset empties the pipeline and clears both registers to zero.
`timescale 1ns / 1ps
module partition_gap_fit_finder
   import pgf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // entry0..3_start, entry0..3_length, entry_kinds, request_size
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // fit_mode, want_logical
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // place_offset
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // found
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [ADDR_W-1:0]     csr_data
);

   logic [ADDR_W-1:0] disk_size_ff;
   logic [HDR_W-1:0]  header_bytes_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   pgf_slot_type      slot [N_ENTRIES];
   logic [ADDR_W-1:0] req1;
   logic [FIT_W-1:0]  fit1;
   logic              log1;

   pgf_gap_type       gap_in [N_GAPS];
   pgf_gap_type       gap_ff [N_GAPS];
   pgf_ext_type       ext_in;
   pgf_ext_type       ext_ff;
   logic [ADDR_W-1:0] req2_ff, req3_ff;
   logic [FIT_W-1:0]  fit2_ff, fit3_ff, fit4_ff;
   logic              log2_ff;

   pgf_lane_en_type   lane_en;
   pgf_fit_type       lane_fit [N_GAPS];

   logic              found;
   logic [ADDR_W-1:0] place;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_size_ff    <= '0;
         header_bytes_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DISK_SIZE:    disk_size_ff    <= csr_data;
            CSR_HEADER_BYTES: header_bytes_ff <= csr_data[HDR_W-1:0];
            default: ;
         endcase
      end
   end

   assign en5 = !v5_ff || rsp_tready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   pgf_sort u_sort (
      .clock       (clock),
      .en          (en1),
      .tdata       (req_tdata),
      .tuser       (req_tuser),
      .slot_ff     (slot),
      .req_size_ff (req1),
      .fit_ff      (fit1),
      .logical_ff  (log1)
   );

   always_comb begin
      logic [SUM_W-1:0] cur;
      logic [SUM_W-1:0] sum;
      cur    = {{(SUM_W-HDR_W){1'b0}}, header_bytes_ff};
      ext_in = '0;
      for (int k = 0; k < N_ENTRIES; k++) begin
         sum = {2'b00, slot[k].start} + {2'b00, slot[k].length};
         gap_in[k].lo     = cur;
         gap_in[k].hi     = {2'b00, slot[k].start};
         gap_in[k].exists = slot[k].used && ({2'b00, slot[k].start} > cur);
         if (slot[k].used) begin
            cur = sum;
         end
      end
      gap_in[N_ENTRIES].lo     = cur;
      gap_in[N_ENTRIES].hi     = {2'b00, disk_size_ff};
      gap_in[N_ENTRIES].exists = cur < {2'b00, disk_size_ff};
      for (int k = N_ENTRIES - 1; k >= 0; k--) begin
         if (slot[k].used && slot[k].kind == KIND_EXTENDED) begin
            ext_in.es  = {2'b00, slot[k].start};
            ext_in.ee  = {2'b00, slot[k].start} + {2'b00, slot[k].length};
            ext_in.has = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         gap_ff  <= gap_in;
         ext_ff  <= ext_in;
         req2_ff <= req1;
         fit2_ff <= fit1;
         log2_ff <= log1;
      end
      if (en3) begin
         req3_ff <= req2_ff;
         fit3_ff <= fit2_ff;
      end
      if (en4) begin
         fit4_ff <= fit3_ff;
      end
   end

   assign lane_en.clip = en3;
   assign lane_en.size = en4;

   for (genvar g = 0; g < N_GAPS; g++) begin : g_lane
      pgf_gap_lane u_lane (
         .clock    (clock),
         .en       (lane_en),
         .gap      (gap_ff[g]),
         .ext      (ext_ff),
         .logical  (log2_ff),
         .req_size (req3_ff),
         .fit_ff   (lane_fit[g])
      );
   end

   pgf_merge u_merge (
      .clock    (clock),
      .en       (en5),
      .lane     (lane_fit),
      .fit_mode (fit4_ff),
      .found_ff (found),
      .place_ff (place)
   );

   assign rsp_tvalid = v5_ff;
   assign rsp_tuser  = found;
   assign rsp_tdata  = {{(RSP_DATA_W-ADDR_W){1'b0}}, place};

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the partition gap fit finder: stream stimulus, placement prediction.
`timescale 1ns / 1ps
module tb_top
   import pgf_pkg::*;
();

   localparam int CYCLE_LIMIT      = 200000;
   localparam int SETTLE_CYCLES    = 12;
   localparam int HOLD_OFF_CYCLES  = 80;
   localparam int HOLD_OFF_AFTER   = 250;
   localparam int N_PHASES         = 8;
   localparam int RANDOM_PER_PHASE = 136;
   localparam int MAX_REPORTS      = 10;
   localparam int KINDS_W          = KIND_W * N_ENTRIES;
   localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

   localparam logic [FIT_W-1:0]  FIT_INVALID    = 2'd3;
   localparam logic [KIND_W-1:0] KIND_OTHER     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_OTHER_ALT = 2'd3;

   typedef struct packed {
      logic [N_ENTRIES-1:0][ADDR_W-1:0] start;
      logic [N_ENTRIES-1:0][ADDR_W-1:0] length;
      logic [KINDS_W-1:0]               kinds;
      logic [ADDR_W-1:0]                req_size;
      logic [FIT_W-1:0]                 fit;
      logic                             logical;
   } placement_req_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] offset;
   } placement_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [ADDR_W-1:0]     csr_data = '0;

   placement_req_type request_queue[$];
   placement_type     expected_placements[$];
   placement_req_type offered_req;
   placement_type     oldest_placement;
   logic [REQ_DATA_W-1:0] req_word;

   logic [ADDR_W-1:0] model_disk_size = '0;
   logic [HDR_W-1:0]  model_header_bytes = '0;

   int  offered_count = 0;
   int  accepted_count = 0;
   int  compared_count = 0;
   int  csr_xfer_count = 0;
   int  fail_count = 0;
   int  cycle_count = 0;
   int  tx_burst_left = 0;
   int  tx_gap_left = 0;
   int  rx_left = 0;
   int  rx_duty = 100;
   logic hold_off = 1'b0;

   partition_gap_fit_finder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   function automatic placement_type predict_placement(placement_req_type r,
                                                       logic [ADDR_W-1:0] disk,
                                                       logic [HDR_W-1:0] hdr);
      logic [SUM_W-1:0]  st [N_ENTRIES];
      logic [SUM_W-1:0]  ln [N_ENTRIES];
      logic [KIND_W-1:0] kd [N_ENTRIES];
      logic [SUM_W-1:0]  gs [N_GAPS];
      logic [SUM_W-1:0]  gz [N_GAPS];
      logic [KIND_W-1:0] k;
      logic [SUM_W-1:0]  cur, es, ee, lo, hi, pick;
      int n, ng, m, ext, j;
      placement_type res;
      n = 0;
      ng = 0;
      pick = '0;
      res = '0;
      for (int i = 0; i < N_ENTRIES; i++) begin
         k = r.kinds[i*KIND_W +: KIND_W];
         if (k != KIND_UNUSED) begin
            j = n;
            while (j > 0 && st[j-1] > SUM_W'(r.start[i])) begin
               st[j] = st[j-1];
               ln[j] = ln[j-1];
               kd[j] = kd[j-1];
               j--;
            end
            st[j] = SUM_W'(r.start[i]);
            ln[j] = SUM_W'(r.length[i]);
            kd[j] = k;
            n++;
         end
      end
      cur = SUM_W'(hdr);
      for (int i = 0; i < n; i++) begin
         if (st[i] > cur) begin
            gs[ng] = cur;
            gz[ng] = st[i] - cur;
            ng++;
         end
         cur = st[i] + ln[i];
      end
      if (cur < SUM_W'(disk)) begin
         gs[ng] = cur;
         gz[ng] = SUM_W'(disk) - cur;
         ng++;
      end
      if (r.logical) begin
         ext = -1;
         for (int i = 0; i < n; i++)
            if (ext < 0 && kd[i] == KIND_EXTENDED) ext = i;
         if (ext < 0) begin
            ng = 0;
         end else begin
            es = st[ext];
            ee = st[ext] + ln[ext];
            m = 0;
            for (int i = 0; i < ng; i++) begin
               lo = (gs[i] > es) ? gs[i] : es;
               hi = (gs[i] + gz[i] < ee) ? gs[i] + gz[i] : ee;
               if (lo < hi) begin
                  gs[m] = lo;
                  gz[m] = hi - lo;
                  m++;
               end
            end
            ng = m;
         end
      end
      if (r.fit != FIT_INVALID) begin
         for (int i = 0; i < ng; i++) begin
            if (gz[i] >= SUM_W'(r.req_size)) begin
               if (r.fit == FIT_FIRST) begin
                  if (!res.found) begin
                     res.found = 1'b1;
                     res.offset = gs[i][ADDR_W-1:0];
                  end
               end else if (!res.found || (r.fit == FIT_BEST && gz[i] < pick) ||
                            (r.fit == FIT_WORST && gz[i] > pick)) begin
                  res.found = 1'b1;
                  res.offset = gs[i][ADDR_W-1:0];
                  pick = gz[i];
               end
            end
         end
      end
      return res;
   endfunction

   function automatic placement_req_type make_req(
         logic [ADDR_W-1:0] s0, logic [ADDR_W-1:0] s1, logic [ADDR_W-1:0] s2,
         logic [ADDR_W-1:0] s3, logic [ADDR_W-1:0] l0, logic [ADDR_W-1:0] l1,
         logic [ADDR_W-1:0] l2, logic [ADDR_W-1:0] l3, logic [KINDS_W-1:0] kinds,
         logic [ADDR_W-1:0] size, logic [FIT_W-1:0] fit, logic logical);
      placement_req_type r;
      r.start    = {s3, s2, s1, s0};
      r.length   = {l3, l2, l1, l0};
      r.kinds    = kinds;
      r.req_size = size;
      r.fit      = fit;
      r.logical  = logical;
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      int sel;
      sel = $urandom_range(0, 3);
      if (sel == 0) return '0;
      if (sel == 1) return ADDR_MAX;
      return ADDR_W'($urandom);
   endfunction

   function automatic placement_req_type gen_request(logic [ADDR_W-1:0] disk,
                                                     logic [HDR_W-1:0] hdr);
      placement_req_type r;
      longint lo, hi, span, es, el;
      int style, ext_slot, sel;
      r = '0;
      lo = longint'(hdr);
      hi = (longint'(disk) > lo + 16) ? longint'(disk) : lo + 100000;
      span = hi - lo;
      style = $urandom_range(0, 9);
      if (style < 2) begin
         for (int i = 0; i < N_ENTRIES; i++) begin
            r.start[i] = rand_addr();
            r.length[i] = rand_addr();
         end
         r.kinds = KINDS_W'($urandom);
      end else if (style < 6) begin
         for (int i = 0; i < N_ENTRIES; i++) begin
            r.start[i] = ADDR_W'(lo + $urandom_range(0, 32'(span)));
            r.length[i] = ADDR_W'($urandom_range(0, 32'(span / 6)));
            r.kinds[i*KIND_W +: KIND_W] = KIND_W'($urandom_range(0, 3));
         end
      end else begin
         ext_slot = $urandom_range(0, N_ENTRIES - 1);
         es = lo + $urandom_range(0, 32'(span / 4));
         el = $urandom_range(32'(span / 4), 32'(span / 2));
         for (int i = 0; i < N_ENTRIES; i++) begin
            if (i == ext_slot) begin
               r.start[i] = ADDR_W'(es);
               r.length[i] = ADDR_W'(el);
               r.kinds[i*KIND_W +: KIND_W] = KIND_EXTENDED;
            end else begin
               r.start[i] = ADDR_W'(es + $urandom_range(0, 32'(el)));
               r.length[i] = ADDR_W'($urandom_range(0, 32'(el / 8)));
               sel = $urandom_range(0, 5);
               r.kinds[i*KIND_W +: KIND_W] = (sel == 0) ? KIND_UNUSED :
                                             (sel == 1) ? KIND_EXTENDED :
                                             (sel < 4)  ? KIND_OTHER : KIND_OTHER_ALT;
            end
         end
      end
      sel = $urandom_range(0, 5);
      if (sel == 0) r.req_size = '0;
      else if (sel == 1) r.req_size = ADDR_W'($urandom_range(1, 64));
      else if (sel < 5) r.req_size = ADDR_W'($urandom_range(0, 32'(span / 4)));
      else r.req_size = rand_addr();
      r.fit = ($urandom_range(0, 9) < 9) ? FIT_W'($urandom_range(0, 2)) : FIT_INVALID;
      r.logical = (style >= 6) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) < 3);
      return r;
   endfunction

   // append one request to the pending queue
   function automatic void enqueue_request(placement_req_type r);
      request_queue.insert(request_queue.size(), r);
   endfunction

   task automatic wait_idle();
      while (!(request_queue.size() == 0 && offered_count == accepted_count &&
               expected_placements.size() == 0))
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
      int prior_count;
      prior_count = csr_xfer_count;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      while (csr_xfer_count == prior_count) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // request driver: bursts with random gaps, item held until its transfer
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && accepted_count != offered_count) begin
      end else if (tx_gap_left > 0) begin
         tx_gap_left--;
         req_tvalid <= 1'b0;
      end else if (request_queue.size() > 0) begin
         offered_req = request_queue.pop_front();
         req_word = '0;
         for (int i = 0; i < N_ENTRIES; i++) begin
            req_word[i*ADDR_W +: ADDR_W] = offered_req.start[i];
            req_word[LEN_BASE + i*ADDR_W +: ADDR_W] = offered_req.length[i];
         end
         req_word[KIND_BASE +: KINDS_W] = offered_req.kinds;
         req_word[REQ_BASE +: ADDR_W] = offered_req.req_size;
         req_tdata  <= req_word;
         req_tuser  <= {offered_req.logical, offered_req.fit};
         req_tvalid <= 1'b1;
         offered_count++;
         if (tx_burst_left > 0) tx_burst_left--;
         if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 24);
            tx_gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // response sink: ready at a random duty cycle of 100, 80, 50 or 15 percent, redrawn after a random run
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_left = $urandom_range(50, 300);
            case ($urandom_range(0, 3))
               0: rx_duty = 100;
               1: rx_duty = 80;
               2: rx_duty = 50;
               default: rx_duty = 15;
            endcase
         end else begin
            rx_left--;
         end
         rsp_tready <= !hold_off && ($urandom_range(1, 100) <= rx_duty);
      end
   end

   // long sink hold-off so the pipeline fills and backs up the request side
   initial begin
      while (accepted_count < HOLD_OFF_AFTER) @(negedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(negedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DISK_SIZE) model_disk_size = csr_data;
            else if (csr_index == CSR_HEADER_BYTES) model_header_bytes = csr_data[HDR_W-1:0];
            csr_xfer_count++;
         end
         if (req_tvalid && req_tready) begin
            expected_placements.insert(expected_placements.size(),
               predict_placement(offered_req, model_disk_size, model_header_bytes));
            accepted_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_placements.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected result: found=%0b offset=%0d", rsp_tuser, rsp_tdata);
            end else begin
               oldest_placement = expected_placements.pop_front();
               if (rsp_tuser !== oldest_placement.found ||
                   rsp_tdata !== RSP_DATA_W'(oldest_placement.offset)) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("result %0d: expected found=%0b offset=%0d, %s=%0b offset=%0d",
                              compared_count, oldest_placement.found, oldest_placement.offset,
                              "got found", rsp_tuser, rsp_tdata);
               end
               compared_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_placements.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic [ADDR_W-1:0] disk;
      logic [HDR_W-1:0]  hdr;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < N_PHASES; p++) begin
         case (p)
            0: begin disk = 1000;           hdr = 100;   end
            1: begin disk = ADDR_MAX;       hdr = 16'hFFFF; end
            2: begin disk = '0;             hdr = '0;    end
            3: begin disk = 1 << 20;        hdr = 4096;  end
            4: begin disk = ADDR_W'($urandom); hdr = HDR_W'($urandom); end
            5: begin disk = 65535;          hdr = 16'hFFFF; end
            6: begin disk = 100;            hdr = 16'hFFFF; end
            default: begin disk = ADDR_MAX; hdr = '0;    end
         endcase
         wait_idle();
         write_csr(CSR_DISK_SIZE, disk);
         write_csr(CSR_HEADER_BYTES, ADDR_W'(hdr));
         if (p == 0) begin
            // empty table: exact fit, one byte too many, invalid mode
            enqueue_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0, FIT_FIRST, 0));
            enqueue_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 900, FIT_BEST, 0));
            enqueue_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 901, FIT_WORST, 0));
            enqueue_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0, FIT_INVALID, 0));
            // unsorted table with a kind-three entry
            enqueue_request(make_req(500, 200, 0, 0, 100, 100, 0, 0, 8'h0E, 150, FIT_FIRST, 0));
            enqueue_request(make_req(500, 200, 0, 0, 100, 100, 0, 0, 8'h0E, 150, FIT_BEST, 0));
            enqueue_request(make_req(500, 200, 0, 0, 100, 100, 0, 0, 8'h0E, 150, FIT_WORST, 0));
            enqueue_request(make_req(500, 200, 0, 0, 100, 100, 0, 0, 8'h0E, 401, FIT_BEST, 0));
            // equal-sized gaps: earliest wins
            enqueue_request(make_req(200, 400, 600, 800, 100, 100, 100, 100, 8'hAA, 50, FIT_BEST, 0));
            enqueue_request(make_req(200, 400, 600, 800, 100, 100, 100, 100, 8'hAA, 50, FIT_WORST, 0));
            enqueue_request(make_req(200, 400, 600, 800, 100, 100, 100, 100, 8'hAA, 100, FIT_FIRST, 0));
            // equal starts keep table order
            enqueue_request(make_req(300, 300, 0, 0, 50, 200, 0, 0, 8'h0A, 400, FIT_FIRST, 0));
            enqueue_request(make_req(300, 300, 0, 0, 200, 50, 0, 0, 8'h0A, 400, FIT_FIRST, 0));
            // overlap moves the cursor backwards
            enqueue_request(make_req(200, 300, 0, 0, 500, 50, 0, 0, 8'h0A, 0, FIT_WORST, 0));
            // logical without and with an extended entry
            enqueue_request(make_req(200, 300, 0, 0, 500, 50, 0, 0, 8'h0A, 0, FIT_FIRST, 1));
            enqueue_request(make_req(200, 300, 0, 0, 600, 100, 0, 0, 8'h09, 0, FIT_FIRST, 1));
            enqueue_request(make_req(200, 300, 0, 0, 600, 100, 0, 0, 8'h09, 500, FIT_BEST, 1));
            enqueue_request(make_req(200, 300, 0, 0, 600, 100, 0, 0, 8'h09, 10, FIT_WORST, 1));
            enqueue_request(make_req(200, 300, 0, 0, 600, 100, 0, 0, 8'h09, 0, FIT_INVALID, 1));
            // two extended entries: the lower start is used
            enqueue_request(make_req(600, 150, 200, 0, 300, 200, 20, 0, 8'h25, 0, FIT_FIRST, 1));
            // entry past the disk end
            enqueue_request(make_req(2000, 0, 0, 0, 10, 0, 0, 0, 8'h02, 0, FIT_FIRST, 0));
            enqueue_request(make_req(2000, 0, 0, 0, 10, 0, 0, 0, 8'h02, 901, FIT_FIRST, 0));
            // field extremes
            enqueue_request(make_req(ADDR_MAX, ADDR_MAX, ADDR_MAX, ADDR_MAX, ADDR_MAX,
                                     ADDR_MAX, ADDR_MAX, ADDR_MAX, 8'hFF, ADDR_MAX,
                                     FIT_FIRST, 1));
            enqueue_request(make_req(ADDR_MAX, ADDR_MAX, ADDR_MAX, ADDR_MAX, ADDR_MAX,
                                     ADDR_MAX, ADDR_MAX, ADDR_MAX, 8'hFF, 0,
                                     FIT_WORST, 0));
            enqueue_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 8'hFF, 0, FIT_BEST, 0));
         end else begin
            repeat (RANDOM_PER_PHASE) enqueue_request(gen_request(disk, hdr));
         end
      end
      wait_idle();
      $display("covered %0d placement requests over %0d disk/header settings",
               accepted_count, N_PHASES);
      $display("compared %0d results, with a %0d-cycle sink hold-off backing up requests",
               compared_count, HOLD_OFF_CYCLES);
      if (fail_count == 0 && expected_placements.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
